// File: src/vpr_pkg.sv
package vpr_pkg;

  // Correlation lanes that are processed; lanes at or above this read zero
  localparam int LANES = 4;
  // Lanes carried on the stream ports
  localparam int MAX_LANES = 4;

  // Phase constants in Q.34 radians
  localparam logic [36:0] TWO_PI_Q34  = 37'd107944301636;
  localparam logic [34:0] HALF_PI_Q34 = 35'd26986075409;
  // 1.0 in Q.30
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Taylor divisors and their exact reciprocals for quotients below 2^30:
  // shift = 30 + clog2(divisor), multiplier = ceil(2^shift / divisor)
  localparam int SIN_K [4] = '{37, 36, 35, 33};
  localparam logic [30:0] SIN_M [4] = '{
    31'(((64'd1 << 37) + 64'd71) / 64'd72),
    31'(((64'd1 << 36) + 64'd41) / 64'd42),
    31'(((64'd1 << 35) + 64'd19) / 64'd20),
    31'(((64'd1 << 33) + 64'd5) / 64'd6)
  };
  localparam int COS_K [5] = '{37, 36, 35, 34, 31};
  localparam logic [30:0] COS_M [5] = '{
    31'(((64'd1 << 37) + 64'd89) / 64'd90),
    31'(((64'd1 << 36) + 64'd55) / 64'd56),
    31'(((64'd1 << 35) + 64'd29) / 64'd30),
    31'(((64'd1 << 34) + 64'd11) / 64'd12),
    31'(((64'd1 << 31) + 64'd1) / 64'd2)
  };

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_ROW_U = 2'd0,
    REG_ROW_V = 2'd1,
    REG_ROW_W = 2'd2,
    REG_SHIFT = 2'd3
  } reg_idx_t;

  // Phase quadrant
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic [2:0][53:0] row;
    logic [53:0]      shift;
  } cfg_t;

  typedef struct packed {
    logic [2:0][31:0]           crd;
    logic [23:0]                scale;
    logic [MAX_LANES-1:0][23:0] re;
    logic [MAX_LANES-1:0][23:0] im;
  } in_t;

  // Payload that rides alongside the phase computation
  typedef struct packed {
    logic [2:0][31:0]           rot;
    logic [MAX_LANES-1:0][23:0] re;
    logic [MAX_LANES-1:0][23:0] im;
  } side_t;

  typedef struct packed {
    logic [29:0] xq;
    quad_t       quad;
    logic        fold;
    side_t       side;
  } phase_t;

  typedef struct packed {
    logic signed [31:0] cs;
    logic signed [31:0] sn;
    side_t              side;
  } rot_t;

  // Residues of 2^i modulo 2*pi in Q.34; the top bit carries weight -2^63
  typedef logic [36:0] res_tbl_t [64];

  function automatic res_tbl_t res_table();
    res_tbl_t    t;
    logic [37:0] r;
    r = 38'd1;
    for (int i = 0; i < 64; i++) begin
      t[i] = r[36:0];
      r = r << 1;
      if (r >= 38'(TWO_PI_Q34)) r = r - 38'(TWO_PI_Q34);
    end
    t[63] = TWO_PI_Q34 - t[63];
    return t;
  endfunction

  localparam res_tbl_t RES = res_table();

endpackage

// File: src/vpr_front.sv
module vpr_front (
  input  logic            clk,
  input  logic            rst,
  input  vpr_pkg::cfg_t   cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  vpr_pkg::in_t    in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output vpr_pkg::phase_t out_item
);

  localparam int N = 11;
  localparam logic [39:0] T1 = 40'(vpr_pkg::TWO_PI_Q34);
  localparam logic [39:0] T2 = T1 << 1;
  localparam logic [39:0] T4 = T1 << 2;
  localparam logic [36:0] H1 = 37'(vpr_pkg::HALF_PI_Q34);
  localparam logic [36:0] H2 = H1 << 1;
  localparam logic [36:0] H3 = H2 + H1;

  logic [N-1:0] v;
  logic [N-1:0] en;

  logic signed [49:0] prod_r [3][3];
  logic signed [49:0] prod_s [3];
  logic [23:0]        scale1;
  logic [23:0]        scale2;
  vpr_pkg::side_t     side [N];
  logic signed [39:0] d2;
  logic [43:0]        pp_lo3;
  logic signed [44:0] pp_hi3;
  logic [63:0]        p4;
  logic [35:0]        low5;
  logic [39:0]        grp5 [4];
  logic [41:0]        s6;
  logic [39:0]        s7;
  logic [37:0]        s8;
  logic [36:0]        a9;
  vpr_pkg::quad_t     quad10;
  logic [34:0]        r10;
  vpr_pkg::quad_t     quad11;
  logic               fold11;
  logic [29:0]        xq11;

  logic signed [51:0] sum_r [3];
  logic signed [51:0] rnd_r [3];
  logic [35:0]        shr [3];
  logic [31:0]        rot_next [3];
  logic signed [51:0] sum_s;
  logic signed [51:0] rnd_s;
  logic [39:0]        grp_next [4];
  logic [39:0]        s7_next;
  logic [39:0]        t8;
  logic [39:0]        s8_wide;
  logic [36:0]        a9_next;
  vpr_pkg::quad_t     quad_next;
  logic [34:0]        r_next;
  logic               fold_next;
  logic [34:0]        x_fold;
  logic [35:0]        x_rnd;

  // Advance a stage when it is empty or its successor moves
  always_comb begin
    en[N-1] = !v[N-1] || out_ready;
    for (int i = N - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[N-1];
  assign out_item  = '{xq: xq11, quad: quad11, fold: fold11, side: side[N-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int i = 1; i < N; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  // Rotation sums with rounding and saturation, phase dot product rounding
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_r[k] = {{2{prod_r[k][0][49]}}, prod_r[k][0]}
               + {{2{prod_r[k][1][49]}}, prod_r[k][1]}
               + {{2{prod_r[k][2][49]}}, prod_r[k][2]};
      rnd_r[k] = sum_r[k] + 52'sd32768;
      shr[k] = rnd_r[k][51:16];
      if (shr[k][35:31] == {5{shr[k][31]}}) begin
        rot_next[k] = shr[k][31:0];
      end else begin
        rot_next[k] = shr[k][35] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
    end
    sum_s = {{2{prod_s[0][49]}}, prod_s[0]}
          + {{2{prod_s[1][49]}}, prod_s[1]}
          + {{2{prod_s[2][49]}}, prod_s[2]};
    rnd_s = sum_s + 52'sd2048;
  end

  // Fold the upper bits of the phase into residues modulo 2*pi
  always_comb begin
    for (int g = 0; g < 4; g++) begin
      grp_next[g] = '0;
      for (int b = 0; b < 7; b++) begin
        if (p4[36 + 7 * g + b]) grp_next[g] = grp_next[g] + 40'(vpr_pkg::RES[36 + 7 * g + b]);
      end
    end
    s7_next = 40'(s6[35:0]);
    for (int b = 0; b < 6; b++) begin
      if (s6[36 + b]) s7_next = s7_next + 40'(vpr_pkg::RES[36 + b]);
    end
    t8 = (s7 >= T4) ? s7 - T4 : s7;
    s8_wide = (t8 >= T2) ? t8 - T2 : t8;
    a9_next = (40'(s8) >= T1) ? 37'(40'(s8) - T1) : s8[36:0];
  end

  // Split the angle into quadrant and remainder, then fold about pi/4
  always_comb begin
    priority if (a9 >= H3) begin
      quad_next = vpr_pkg::QUAD_3;
      r_next = 35'(a9 - H3);
    end else if (a9 >= H2) begin
      quad_next = vpr_pkg::QUAD_2;
      r_next = 35'(a9 - H2);
    end else if (a9 >= H1) begin
      quad_next = vpr_pkg::QUAD_1;
      r_next = 35'(a9 - H1);
    end else begin
      quad_next = vpr_pkg::QUAD_0;
      r_next = a9[34:0];
    end
    fold_next = {r10, 1'b0} > {1'b0, vpr_pkg::HALF_PI_Q34};
    x_fold = fold_next ? vpr_pkg::HALF_PI_Q34 - r10 : r10;
    x_rnd = {1'b0, x_fold} + 36'd8;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[k][j] <= $signed(cfg.row[k][18*j +: 18]) * $signed(in_item.crd[j]);
        end
      end
      for (int j = 0; j < 3; j++) begin
        prod_s[j] <= $signed(cfg.shift[18*j +: 18]) * $signed(in_item.crd[j]);
      end
      scale1 <= in_item.scale;
      side[0] <= {in_item.crd, in_item.re, in_item.im};
    end
    if (en[1]) begin
      side[1].rot <= {rot_next[2], rot_next[1], rot_next[0]};
      side[1].re <= side[0].re;
      side[1].im <= side[0].im;
      d2 <= rnd_s[51:12];
      scale2 <= scale1;
    end
    if (en[2]) begin
      pp_lo3 <= d2[19:0] * scale2;
      pp_hi3 <= $signed(d2[39:20]) * $signed({1'b0, scale2});
      side[2] <= side[1];
    end
    if (en[3]) begin
      p4 <= 64'({{19{pp_hi3[44]}}, pp_hi3} << 20) + 64'(pp_lo3);
      side[3] <= side[2];
    end
    if (en[4]) begin
      low5 <= p4[35:0];
      grp5 <= grp_next;
      side[4] <= side[3];
    end
    if (en[5]) begin
      s6 <= 42'(low5) + 42'(grp5[0]) + 42'(grp5[1]) + 42'(grp5[2]) + 42'(grp5[3]);
      side[5] <= side[4];
    end
    if (en[6]) begin
      s7 <= s7_next;
      side[6] <= side[5];
    end
    if (en[7]) begin
      s8 <= s8_wide[37:0];
      side[7] <= side[6];
    end
    if (en[8]) begin
      a9 <= a9_next;
      side[8] <= side[7];
    end
    if (en[9]) begin
      quad10 <= quad_next;
      r10 <= r_next;
      side[9] <= side[8];
    end
    if (en[10]) begin
      quad11 <= quad10;
      fold11 <= fold_next;
      xq11 <= x_rnd[33:4];
      side[10] <= side[9];
    end
  end

endmodule

// File: src/vpr_sincos.sv
module vpr_sincos (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  vpr_pkg::phase_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output vpr_pkg::rot_t   out_item
);

  localparam int N = 12;

  logic [N-1:0] v;
  logic [N-1:0] en;

  // Per-stage carry of the argument and its square
  logic [29:0]    x_r  [9];
  logic [29:0]    x2_r [9];
  // Horner terms at the start of each step, and products in mid-step
  logic [30:0]    ts [6];
  logic [30:0]    tc [6];
  logic [29:0]    vs [5];
  logic [29:0]    vc [5];
  vpr_pkg::quad_t quad_r [11];
  logic           fold_r [11];
  vpr_pkg::side_t side_r [11];
  logic signed [31:0] cs_o;
  logic signed [31:0] sn_o;
  vpr_pkg::side_t side_o;

  logic [59:0]        sq;
  logic [60:0]        ma_s [4];
  logic [60:0]        ma_c [5];
  logic [60:0]        ma_s4;
  logic [60:0]        mb_s [4];
  logic [60:0]        mb_c [5];
  logic [30:0]        qs [4];
  logic [30:0]        qc [5];
  logic signed [31:0] fs;
  logic signed [31:0] fc;
  logic signed [31:0] cs_next;
  logic signed [31:0] sn_next;

  always_comb begin
    en[N-1] = !v[N-1] || out_ready;
    for (int i = N - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[N-1];
  assign out_item  = '{cs: cs_o, sn: sn_o, side: side_o};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int i = 1; i < N; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  // Horner step products and constant-reciprocal divisions
  always_comb begin
    sq = in_item.xq * in_item.xq;
    for (int k = 0; k < 4; k++) begin
      ma_s[k] = x2_r[2*k] * ts[k];
      mb_s[k] = vs[k] * vpr_pkg::SIN_M[k];
      qs[k] = 31'(mb_s[k] >> vpr_pkg::SIN_K[k]);
    end
    for (int k = 0; k < 5; k++) begin
      ma_c[k] = x2_r[2*k] * tc[k];
      mb_c[k] = vc[k] * vpr_pkg::COS_M[k];
      qc[k] = 31'(mb_c[k] >> vpr_pkg::COS_K[k]);
    end
    ma_s4 = x_r[8] * ts[4];
  end

  // Undo the fold and apply quadrant signs
  always_comb begin
    fs = fold_r[10] ? $signed({1'b0, tc[5]}) : $signed({1'b0, ts[5]});
    fc = fold_r[10] ? $signed({1'b0, ts[5]}) : $signed({1'b0, tc[5]});
    unique case (quad_r[10])
      vpr_pkg::QUAD_0: begin
        cs_next = fc;
        sn_next = fs;
      end
      vpr_pkg::QUAD_1: begin
        cs_next = -fs;
        sn_next = fc;
      end
      vpr_pkg::QUAD_2: begin
        cs_next = -fc;
        sn_next = -fs;
      end
      vpr_pkg::QUAD_3: begin
        cs_next = fs;
        sn_next = -fc;
      end
      default: begin
        cs_next = fc;
        sn_next = fs;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r[0] <= in_item.xq;
      x2_r[0] <= sq[59:30];
      ts[0] <= vpr_pkg::ONE_Q30;
      tc[0] <= vpr_pkg::ONE_Q30;
      quad_r[0] <= in_item.quad;
      fold_r[0] <= in_item.fold;
      side_r[0] <= in_item.side;
    end
    for (int i = 1; i < 11; i++) begin
      if (en[i]) begin
        quad_r[i] <= quad_r[i-1];
        fold_r[i] <= fold_r[i-1];
        side_r[i] <= side_r[i-1];
      end
    end
    for (int i = 1; i < 9; i++) begin
      if (en[i]) begin
        x_r[i] <= x_r[i-1];
        x2_r[i] <= x2_r[i-1];
      end
    end
    for (int k = 0; k < 5; k++) begin
      if (en[2*k+1]) vc[k] <= ma_c[k][59:30];
      if (en[2*k+2]) tc[k+1] <= vpr_pkg::ONE_Q30 - qc[k];
    end
    for (int k = 0; k < 4; k++) begin
      if (en[2*k+1]) vs[k] <= ma_s[k][59:30];
      if (en[2*k+2]) ts[k+1] <= vpr_pkg::ONE_Q30 - qs[k];
    end
    // Final sine product x * t
    if (en[9]) vs[4] <= ma_s4[59:30];
    if (en[10]) ts[5] <= {1'b0, vs[4]};
    if (en[11]) begin
      cs_o <= cs_next;
      sn_o <= sn_next;
      side_o <= side_r[10];
    end
  end

endmodule

// File: src/vpr_cmul.sv
module vpr_cmul (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  vpr_pkg::rot_t  in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output vpr_pkg::side_t out_item
);

  localparam int L = vpr_pkg::MAX_LANES;

  logic [1:0] v;
  logic [1:0] en;

  logic signed [55:0] m_rc [L];
  logic signed [55:0] m_is [L];
  logic signed [55:0] m_rs [L];
  logic signed [55:0] m_ic [L];
  logic [2:0][31:0]   rot0;

  logic signed [56:0] re_sum [L];
  logic signed [56:0] im_sum [L];
  logic [26:0]        re_sh [L];
  logic [26:0]        im_sh [L];
  logic [23:0]        re_sat [L];
  logic [23:0]        im_sat [L];

  assign en[1] = !v[1] || out_ready;
  assign en[0] = !v[0] || en[1];
  assign in_ready  = en[0];
  assign out_valid = v[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      if (en[1]) v[1] <= v[0];
    end
  end

  // Round at Q.30 and saturate to the sample width
  always_comb begin
    for (int k = 0; k < L; k++) begin
      re_sum[k] = {m_rc[k][55], m_rc[k]} - {m_is[k][55], m_is[k]} + 57'sd536870912;
      im_sum[k] = {m_rs[k][55], m_rs[k]} + {m_ic[k][55], m_ic[k]} + 57'sd536870912;
      re_sh[k] = re_sum[k][56:30];
      im_sh[k] = im_sum[k][56:30];
      if (re_sh[k][26:23] == {4{re_sh[k][23]}}) re_sat[k] = re_sh[k][23:0];
      else re_sat[k] = re_sh[k][26] ? 24'h80_0000 : 24'h7F_FFFF;
      if (im_sh[k][26:23] == {4{im_sh[k][23]}}) im_sat[k] = im_sh[k][23:0];
      else im_sat[k] = im_sh[k][26] ? 24'h80_0000 : 24'h7F_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < L; k++) begin
        m_rc[k] <= $signed(in_item.side.re[k]) * $signed(in_item.cs);
        m_is[k] <= $signed(in_item.side.im[k]) * $signed(in_item.sn);
        m_rs[k] <= $signed(in_item.side.re[k]) * $signed(in_item.sn);
        m_ic[k] <= $signed(in_item.side.im[k]) * $signed(in_item.cs);
      end
      rot0 <= in_item.side.rot;
    end
    if (en[1]) begin
      out_item.rot <= rot0;
      for (int k = 0; k < L; k++) begin
        out_item.re[k] <= (k < vpr_pkg::LANES) ? re_sat[k] : '0;
        out_item.im[k] <= (k < vpr_pkg::LANES) ? im_sat[k] : '0;
      end
    end
  end

endmodule

// File: src/visibility_phase_rotator.sv
// Visibility phase rotator: each transfer carries one baseline's u,v,w, the
// channel scale 2*pi*f/c and four complex samples. The block returns u,v,w
// rotated by the configured 3x3 matrix and the samples multiplied by
// cos+j*sin of (shift vector . uvw) * scale, reduced modulo 2*pi. It takes one
// item every cycle while the output is not stalled. The pipeline holds 11
// stages for the matrix products, the phase product and the modulo reduction,
// 12 for the Horner sine and cosine (two stages per term, one multiplier each),
// and 2 for the complex multiply with its output register. Stalls back up
// stage by stage, so bubbles are squeezed out.
// After reset the matrix is identity and the shift vector zero; write
// configuration only while the pipeline is empty.
module visibility_phase_rotator (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [53:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // coord_u, coord_v, coord_w, chan_scale, sample0_re, sample0_im, sample1_re,
  // sample1_im, sample2_re, sample2_im, sample3_re, sample3_im
  input  logic [311:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // rotated_u, rotated_v, rotated_w, out0_re, out0_im, out1_re, out1_im,
  // out2_re, out2_im, out3_re, out3_im
  output logic [287:0] m_axis_tdata
);

  vpr_pkg::cfg_t   cfg;
  vpr_pkg::in_t    in_item;
  vpr_pkg::phase_t ph_item;
  vpr_pkg::rot_t   rot_item;
  vpr_pkg::side_t  out_item;
  logic            ph_valid;
  logic            ph_ready;
  logic            rot_valid;
  logic            rot_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row[0] <= 54'd65536;
      cfg.row[1] <= 54'd17179869184;
      cfg.row[2] <= 54'd4503599627370496;
      cfg.shift <= '0;
    end else if (cfg_we) begin
      unique case (vpr_pkg::reg_idx_t'(cfg_index))
        vpr_pkg::REG_ROW_U: cfg.row[0] <= cfg_data;
        vpr_pkg::REG_ROW_V: cfg.row[1] <= cfg_data;
        vpr_pkg::REG_ROW_W: cfg.row[2] <= cfg_data;
        vpr_pkg::REG_SHIFT: cfg.shift <= cfg_data;
        default: cfg.shift <= cfg.shift;
      endcase
    end
  end

  // Unpack the input transfer and pack the result
  always_comb begin
    in_item.crd[0] = s_axis_tdata[31:0];
    in_item.crd[1] = s_axis_tdata[63:32];
    in_item.crd[2] = s_axis_tdata[95:64];
    in_item.scale = s_axis_tdata[119:96];
    m_axis_tdata[31:0] = out_item.rot[0];
    m_axis_tdata[63:32] = out_item.rot[1];
    m_axis_tdata[95:64] = out_item.rot[2];
    for (int k = 0; k < vpr_pkg::MAX_LANES; k++) begin
      in_item.re[k] = s_axis_tdata[120 + 48 * k +: 24];
      in_item.im[k] = s_axis_tdata[144 + 48 * k +: 24];
      m_axis_tdata[96 + 48 * k +: 24] = out_item.re[k];
      m_axis_tdata[120 + 48 * k +: 24] = out_item.im[k];
    end
  end

  vpr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (in_item),
    .out_valid (ph_valid),
    .out_ready (ph_ready),
    .out_item  (ph_item)
  );

  vpr_sincos u_sincos (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ph_valid),
    .in_ready  (ph_ready),
    .in_item   (ph_item),
    .out_valid (rot_valid),
    .out_ready (rot_ready),
    .out_item  (rot_item)
  );

  vpr_cmul u_cmul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rot_valid),
    .in_ready  (rot_ready),
    .in_item   (rot_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (out_item)
  );

endmodule

// File: src/vpr_checker.sv
module vpr_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [287:0] m_axis_tdata
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // Input is refused only when the output is backed up
  a_refuse_only_stalled: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input refused while output is free");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind visibility_phase_rotator vpr_checker u_vpr_checker (.*);
